>>> hdl/pdq_pkg.sv
// ----------------------------------------------------------------------------
// pdq_pkg
// Types, constants and helpers shared by the priority drop event queue.
// ----------------------------------------------------------------------------
package pdq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int MASK_W      = 16;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        FUNC_POST  = 2'd0,
        FUNC_TAKE  = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        DROP_NONE  = 2'd0,
        DROP_NEW   = 2'd1,
        DROP_EVICT = 2'd2
    } drop_t;

    typedef struct packed {
        func_t        func;
        logic [3:0]   event_code;
        logic [31:0]  window_gen;
        logic [31:0]  conn_gen;
        logic [7:0]   conn_id;
        logic [47:0]  remote_addr;
        logic         remote_addr_valid;
        logic [7:0]   remote_type;
    } in_t;

    typedef struct packed {
        logic         accepted;
        drop_t        drop_kind;
        logic [3:0]   dropped_code;
        logic         item_valid;
        logic [3:0]   out_event_code;
        logic [31:0]  out_window_gen;
        logic [31:0]  out_conn_gen;
        logic [7:0]   out_conn_id;
        logic [47:0]  out_remote_addr;
        logic         out_remote_addr_valid;
        logic [7:0]   out_remote_type;
        logic         pending;
    } out_t;

    // One stored event record.
    typedef struct packed {
        logic [3:0]   code;
        logic [31:0]  window_gen;
        logic [31:0]  conn_gen;
        logic [7:0]   conn_id;
        logic [47:0]  remote_addr;
        logic         remote_addr_valid;
        logic [7:0]   remote_type;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH_RD,
        ST_SEARCH_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_EVICT,
        ST_APPEND,
        ST_TAKE_RD,
        ST_TAKE_CAP,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic k_clr;
        logic k_inc;
        logic rd_en;
        logic rd_next;
        logic wr_en;
        logic wr_shift;
        logic search_chk;
        logic evict_commit;
        logic append_commit;
        logic take_commit;
        logic set_drop_new;
        logic flush;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  full;
        logic  empty;
        logic  new_term;
        logic  rd_term;
        logic  k_last;
        logic  out_free;
    } sts_t;

    // Ring index plus an offset of at most one full turn.
    function automatic idx_t wrap_add(idx_t base, cnt_t offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offs);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> hdl/priority_drop_event_queue.sv
// ----------------------------------------------------------------------------
// priority_drop_event_queue
// Bounded ring queue of event records in which terminal events take priority.
// Operations arrive one per transaction on the s_ channel and each returns
// exactly one result on the m_ channel. Posts to a queue with room append;
// a non-terminal post to a full queue is dropped; a terminal post to a full
// queue evicts the oldest non-terminal record (the head when all are
// terminal), closes the gap and appends. One operation is in flight at a
// time, and the next one is taken while the previous result waits in the
// output register. The eviction search and the gap-closing shift go
// through the single read port of the record RAM, whose read data is
// registered. terminal_mask is written through cfg_we and cfg_wdata; the
// user must do so only while no operation is in progress, as the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module priority_drop_event_queue
    import pdq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    pdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pdq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while one is in progress");
`endif

endmodule

>>> hdl/pdq_ram.sv
// ----------------------------------------------------------------------------
// pdq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/pdq_ctrl.sv
// ----------------------------------------------------------------------------
// pdq_ctrl
// Sequencer for the event queue: dispatches each operation and steps the
// eviction search and the gap-closing shift through the record RAM.
// ----------------------------------------------------------------------------
module pdq_ctrl
    import pdq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (sts.func)
                    FUNC_POST: begin
                        if (!sts.full) begin
                            state_next = ST_APPEND;
                        end else if (sts.new_term) begin
                            state_next = ST_SEARCH_RD;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    FUNC_TAKE:  state_next = sts.empty ? ST_DONE : ST_TAKE_RD;
                    FUNC_FLUSH: state_next = ST_DONE;
                    FUNC_QUERY: state_next = ST_DONE;
                endcase
            end
            ST_SEARCH_RD:  state_next = ST_SEARCH_CHK;
            ST_SEARCH_CHK: begin
                if (!sts.rd_term || sts.k_last) begin
                    state_next = ST_SHIFT_RD;
                end else begin
                    state_next = ST_SEARCH_RD;
                end
            end
            ST_SHIFT_RD:   state_next = sts.k_last ? ST_EVICT : ST_SHIFT_WR;
            ST_SHIFT_WR:   state_next = ST_SHIFT_RD;
            ST_EVICT:      state_next = ST_APPEND;
            ST_APPEND:     state_next = ST_DONE;
            ST_TAKE_RD:    state_next = ST_TAKE_CAP;
            ST_TAKE_CAP:   state_next = ST_DONE;
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                cmd.k_clr   = s_valid;
            end
            ST_DISPATCH: begin
                cmd.set_drop_new = (sts.func == FUNC_POST) && sts.full && !sts.new_term;
                cmd.flush        = (sts.func == FUNC_FLUSH);
            end
            ST_SEARCH_RD: begin
                cmd.rd_en = 1'b1;
            end
            ST_SEARCH_CHK: begin
                cmd.search_chk = 1'b1;
                // When every queued record is terminal the head is the victim.
                cmd.k_clr = sts.rd_term && sts.k_last;
                cmd.k_inc = sts.rd_term && !sts.k_last;
            end
            ST_SHIFT_RD: begin
                cmd.rd_en   = !sts.k_last;
                cmd.rd_next = 1'b1;
            end
            ST_SHIFT_WR: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.k_inc    = 1'b1;
            end
            ST_EVICT: begin
                cmd.evict_commit = 1'b1;
            end
            ST_APPEND: begin
                cmd.wr_en         = 1'b1;
                cmd.append_commit = 1'b1;
            end
            ST_TAKE_RD: begin
                cmd.rd_en = 1'b1;
            end
            ST_TAKE_CAP: begin
                cmd.take_commit = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/pdq_datapath.sv
// ----------------------------------------------------------------------------
// pdq_datapath
// Ring pointers, fill count, record RAM, the captured transaction and the
// result register of the event queue.
// ----------------------------------------------------------------------------
module pdq_datapath
    import pdq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  in_t               s_data,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_wdata,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data
);

    idx_t              head_reg, head_next;
    idx_t              tail_reg, tail_next;
    cnt_t              fill_reg, fill_next;
    idx_t              k_reg, k_next;
    in_t               in_reg, in_next;
    out_t              res_reg, res_next;
    out_t              m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;
    logic [MASK_W-1:0] terminal_mask_reg, terminal_mask_next;

    cnt_t k_ext;
    cnt_t k_plus1;
    idx_t addr_k;
    idx_t addr_k1;
    rec_t new_rec;
    rec_t rd_data;
    rec_t wr_data;
    idx_t wr_addr;
    idx_t rd_addr;
    logic rd_term;

    assign k_ext   = CNT_W'(k_reg);
    assign k_plus1 = k_ext + CNT_W'(1);
    assign addr_k  = wrap_add(head_reg, k_ext);
    assign addr_k1 = wrap_add(head_reg, k_plus1);

    always_comb begin
        new_rec.code              = in_reg.event_code;
        new_rec.window_gen        = in_reg.window_gen;
        new_rec.conn_gen          = in_reg.conn_gen;
        new_rec.conn_id           = in_reg.conn_id;
        new_rec.remote_addr       = in_reg.remote_addr;
        new_rec.remote_addr_valid = in_reg.remote_addr_valid;
        new_rec.remote_type       = in_reg.remote_type;
    end

    assign wr_data = cmd.wr_shift ? rd_data : new_rec;
    assign wr_addr = cmd.wr_shift ? addr_k : tail_reg;
    assign rd_addr = cmd.rd_next ? addr_k1 : addr_k;

    pdq_ram #(
        .WIDTH(REC_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_term = terminal_mask_reg[rd_data.code];

    always_comb begin
        sts.func     = in_reg.func;
        sts.full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
        sts.empty    = (fill_reg == '0);
        sts.new_term = terminal_mask_reg[in_reg.event_code];
        sts.rd_term  = rd_term;
        sts.k_last   = (k_plus1 >= fill_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        head_next          = head_reg;
        tail_next          = tail_reg;
        fill_next          = fill_reg;
        k_next             = k_reg;
        in_next            = in_reg;
        res_next           = res_reg;
        m_data_next        = m_data_reg;
        m_valid_next       = m_valid_reg;
        terminal_mask_next = terminal_mask_reg;

        if (cfg_we) begin
            terminal_mask_next = cfg_wdata;
        end

        if (cmd.load_in) begin
            in_next  = s_data;
            res_next = '0;
        end

        if (cmd.k_clr) begin
            k_next = '0;
        end else if (cmd.k_inc) begin
            k_next = k_reg + IDX_W'(1);
        end

        // The head's code is kept as the victim until a non-terminal record shows up.
        if (cmd.search_chk && ((k_reg == '0) || !rd_term)) begin
            res_next.dropped_code = rd_data.code;
        end

        if (cmd.set_drop_new) begin
            res_next.drop_kind    = DROP_NEW;
            res_next.dropped_code = in_reg.event_code;
        end

        if (cmd.evict_commit) begin
            res_next.drop_kind = DROP_EVICT;
            tail_next          = wrap_add(head_reg, fill_reg - CNT_W'(1));
            fill_next          = fill_reg - CNT_W'(1);
        end

        if (cmd.append_commit) begin
            res_next.accepted = 1'b1;
            tail_next         = wrap_add(tail_reg, CNT_W'(1));
            fill_next         = fill_reg + CNT_W'(1);
        end

        if (cmd.take_commit) begin
            res_next.item_valid            = 1'b1;
            res_next.out_event_code        = rd_data.code;
            res_next.out_window_gen        = rd_data.window_gen;
            res_next.out_conn_gen          = rd_data.conn_gen;
            res_next.out_conn_id           = rd_data.conn_id;
            res_next.out_remote_addr       = rd_data.remote_addr;
            res_next.out_remote_addr_valid = rd_data.remote_addr_valid;
            res_next.out_remote_type       = rd_data.remote_type;
            head_next                      = wrap_add(head_reg, CNT_W'(1));
            fill_next                      = fill_reg - CNT_W'(1);
            if (fill_reg == CNT_W'(1)) begin
                tail_next = wrap_add(head_reg, CNT_W'(1));
            end
        end

        if (cmd.flush) begin
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_data_next         = res_reg;
            m_data_next.pending = (fill_reg != '0);
            m_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg          <= '0;
            tail_reg          <= '0;
            fill_reg          <= '0;
            m_valid_reg       <= 1'b0;
            terminal_mask_reg <= '0;
        end else begin
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            fill_reg          <= fill_next;
            m_valid_reg       <= m_valid_next;
            terminal_mask_reg <= terminal_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        in_reg     <= in_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count exceeds queue depth");

    a_ring_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg == wrap_add(head_reg, fill_reg))
        else $error("tail pointer does not match head plus fill count");

    a_take_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_commit |=> fill_reg == $past(fill_reg) - CNT_W'(1))
        else $error("take did not remove exactly one record");
`endif

endmodule

>>> bench/priority_drop_event_queue_tb.sv
// ----------------------------------------------------------------------------
// priority_drop_event_queue_tb
// Self-checking bench for the priority drop event queue. A short directed
// script walks the corner cases: empty queue, field extremes, a full queue
// dropping a new record, evictions in the middle and at the head, and flush.
// Random traffic follows under several terminal masks. Every transaction on
// the s_ channel is run through a behavioral copy of the queue, and each m_
// transaction is compared field by field with the oldest expected reply.
// ----------------------------------------------------------------------------
module priority_drop_event_queue_tb
    import pdq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_ITEMS = 75;
    localparam int HOLD_CYCLES = 150;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_t               s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_t              m_data;
    logic              cfg_we = 1'b0;
    logic [MASK_W-1:0] cfg_wdata = '0;

    priority_drop_event_queue u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Behavioral copy of the event ring.
    rec_t              qslots [QUEUE_DEPTH];
    int                qhead = 0;
    int                qtail = 0;
    int                qfill = 0;
    logic [MASK_W-1:0] term_mask = '0;

    out_t awaited_replies [$];
    out_t head_want;

    int mismatches = 0;
    int ops_sent = 0;
    int n_evicted = 0;
    int n_dropped = 0;
    int n_popped = 0;
    int tx_idle_pct = 12;
    int rx_idle_pct = 46;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    typedef struct {
        bit                set_mask;
        logic [MASK_W-1:0] mask;
        in_t               op;
        bit                typed;
        out_t              want;
    } stim_row_t;

    stim_row_t stim_rows [$];

    function automatic out_t queue_op_result(in_t x);
        out_t r;
        bit   room;
        bit   found;
        int   victim;
        int   k;
        r = '0;
        if (x.func == FUNC_POST) begin
            room = 1'b1;
            if (qfill >= QUEUE_DEPTH) begin
                if (term_mask[x.event_code]) begin
                    // Oldest non-terminal record goes; the head if all are terminal.
                    found = 1'b0;
                    victim = 0;
                    for (k = 0; k < qfill; k++) begin
                        if (!found && !term_mask[qslots[(qhead + k) % QUEUE_DEPTH].code]) begin
                            victim = k;
                            found = 1'b1;
                        end
                    end
                    r.drop_kind = DROP_EVICT;
                    r.dropped_code = qslots[(qhead + victim) % QUEUE_DEPTH].code;
                    for (k = victim; k + 1 < qfill; k++) begin
                        qslots[(qhead + k) % QUEUE_DEPTH] = qslots[(qhead + k + 1) % QUEUE_DEPTH];
                    end
                    qtail = (qhead + qfill - 1) % QUEUE_DEPTH;
                    qfill--;
                end else begin
                    r.drop_kind = DROP_NEW;
                    r.dropped_code = x.event_code;
                    room = 1'b0;
                end
            end
            if (room) begin
                qslots[qtail].code = x.event_code;
                qslots[qtail].window_gen = x.window_gen;
                qslots[qtail].conn_gen = x.conn_gen;
                qslots[qtail].conn_id = x.conn_id;
                qslots[qtail].remote_addr = x.remote_addr;
                qslots[qtail].remote_addr_valid = x.remote_addr_valid;
                qslots[qtail].remote_type = x.remote_type;
                qtail = (qtail + 1) % QUEUE_DEPTH;
                qfill++;
                r.accepted = 1'b1;
            end
        end else if (x.func == FUNC_TAKE) begin
            if (qfill != 0) begin
                r.item_valid = 1'b1;
                r.out_event_code = qslots[qhead].code;
                r.out_window_gen = qslots[qhead].window_gen;
                r.out_conn_gen = qslots[qhead].conn_gen;
                r.out_conn_id = qslots[qhead].conn_id;
                r.out_remote_addr = qslots[qhead].remote_addr;
                r.out_remote_addr_valid = qslots[qhead].remote_addr_valid;
                r.out_remote_type = qslots[qhead].remote_type;
                qhead = (qhead + 1) % QUEUE_DEPTH;
                qfill--;
                if (qfill == 0) begin
                    qtail = qhead;
                end
            end
        end else if (x.func == FUNC_FLUSH) begin
            qhead = 0;
            qtail = 0;
            qfill = 0;
        end
        r.pending = (qfill != 0);
        return r;
    endfunction

    function automatic in_t make_op(func_t f, logic [3:0] code, logic [31:0] seed);
        in_t x;
        x.func = f;
        x.event_code = code;
        x.window_gen = seed;
        x.conn_gen = ~seed;
        x.conn_id = seed[7:0];
        x.remote_addr = {seed[15:0], ~seed};
        x.remote_addr_valid = seed[0];
        x.remote_type = seed[15:8];
        return x;
    endfunction

    function automatic in_t random_op(int post_pct, int take_pct);
        in_t x;
        int  p;
        p = $urandom_range(99);
        if (p < post_pct) begin
            x.func = FUNC_POST;
        end else if (p < post_pct + take_pct) begin
            x.func = FUNC_TAKE;
        end else if (p < post_pct + take_pct + 4) begin
            x.func = FUNC_FLUSH;
        end else begin
            x.func = FUNC_QUERY;
        end
        x.event_code = 4'($urandom_range(15));
        x.window_gen = $urandom;
        x.conn_gen = $urandom;
        x.conn_id = 8'($urandom_range(255));
        x.remote_addr = 48'({$urandom, $urandom});
        x.remote_addr_valid = 1'($urandom_range(1));
        x.remote_type = 8'($urandom_range(255));
        return x;
    endfunction

    function automatic bit field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_op(in_t op);
        stim_rows.push_back('{1'b0, '0, op, 1'b0, '0});
    endtask

    task automatic add_typed(in_t op, out_t want);
        stim_rows.push_back('{1'b0, '0, op, 1'b1, want});
    endtask

    task automatic add_mask(logic [MASK_W-1:0] m);
        stim_rows.push_back('{1'b1, m, '0, 1'b0, '0});
    endtask

    // Offers one operation; the expected reply is queued at the accepting edge.
    task automatic send_op(in_t op, bit typed, out_t want);
        out_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= op;
        do @(posedge aclk); while (!s_ready);
        predicted = queue_op_result(op);
        awaited_replies.push_back(typed ? want : predicted);
        ops_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_mask(logic [MASK_W-1:0] m);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        term_mask = m;
    endtask

    // Receiver: random back-pressure plus an occasional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_ready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t ns: reply with nothing expected, expected none, actual 0x%0h",
                         $time, m_data);
                mismatches++;
            end else begin
                head_want = awaited_replies.pop_front();
                if (head_want !== m_data) begin
                    void'(field_differs("accepted", 64'(head_want.accepted),
                                        64'(m_data.accepted)));
                    void'(field_differs("drop_kind", 64'(head_want.drop_kind),
                                        64'(m_data.drop_kind)));
                    void'(field_differs("dropped_code", 64'(head_want.dropped_code),
                                        64'(m_data.dropped_code)));
                    void'(field_differs("item_valid", 64'(head_want.item_valid),
                                        64'(m_data.item_valid)));
                    void'(field_differs("out_event_code", 64'(head_want.out_event_code),
                                        64'(m_data.out_event_code)));
                    void'(field_differs("out_window_gen", 64'(head_want.out_window_gen),
                                        64'(m_data.out_window_gen)));
                    void'(field_differs("out_conn_gen", 64'(head_want.out_conn_gen),
                                        64'(m_data.out_conn_gen)));
                    void'(field_differs("out_conn_id", 64'(head_want.out_conn_id),
                                        64'(m_data.out_conn_id)));
                    void'(field_differs("out_remote_addr", 64'(head_want.out_remote_addr),
                                        64'(m_data.out_remote_addr)));
                    void'(field_differs("out_remote_addr_valid",
                                        64'(head_want.out_remote_addr_valid),
                                        64'(m_data.out_remote_addr_valid)));
                    void'(field_differs("out_remote_type", 64'(head_want.out_remote_type),
                                        64'(m_data.out_remote_type)));
                    void'(field_differs("pending", 64'(head_want.pending),
                                        64'(m_data.pending)));
                    mismatches++;
                end
                if (head_want.drop_kind == DROP_EVICT) n_evicted++;
                if (head_want.drop_kind == DROP_NEW) n_dropped++;
                if (head_want.item_valid) n_popped++;
            end
        end
    end

    initial begin
        in_t               op;
        out_t              drop_want;
        logic [MASK_W-1:0] seg_mask;
        int                phase;
        int                seg;
        int                i;
        int                post_pct;

        // Empty queue, field extremes, then fill and overflow.
        add_typed(make_op(FUNC_QUERY, 4'h0, 32'h0), '0);
        add_typed(make_op(FUNC_TAKE, 4'h0, 32'h0), '0);
        op = '0;
        add_op(op);
        op = '1;
        op.func = FUNC_POST;
        add_op(op);
        add_op(make_op(FUNC_TAKE, 4'h0, 32'h0));
        add_op(make_op(FUNC_TAKE, 4'h0, 32'h0));
        add_typed(make_op(FUNC_TAKE, 4'h0, 32'h0), '0);
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            add_op(make_op(FUNC_POST, 4'(i), $urandom));
        end
        // Non-terminal post to a full queue loses the new record.
        drop_want = '0;
        drop_want.drop_kind = DROP_NEW;
        drop_want.dropped_code = 4'h9;
        drop_want.pending = 1'b1;
        add_typed(make_op(FUNC_POST, 4'h9, 32'h1234_5678), drop_want);
        // Terminal posts evict from the middle, then from the head when all are terminal.
        add_mask(16'h8005);
        add_op(make_op(FUNC_POST, 4'hf, 32'hdead_beef));
        add_op(make_op(FUNC_POST, 4'h2, 32'h0f0f_0f0f));
        add_mask(16'hffff);
        add_op(make_op(FUNC_POST, 4'h5, 32'ha5a5_5a5a));
        add_op(make_op(FUNC_TAKE, 4'h0, 32'h0));
        add_typed(make_op(FUNC_FLUSH, 4'h0, 32'h0), '0);
        add_typed(make_op(FUNC_TAKE, 4'h0, 32'h0), '0);
        add_op(make_op(FUNC_POST, 4'h3, 32'h5555_aaaa));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].set_mask) begin
                write_mask(stim_rows[r].mask);
            end else begin
                send_op(stim_rows[r].op, stim_rows[r].typed, stim_rows[r].want);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 46 : 0;
            rx_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 12 : 0;
            for (seg = 0; seg < 3; seg++) begin
                if (phase == 0 && seg == 0) begin
                    seg_mask = 16'h0000;
                end else if (phase == 0 && seg == 1) begin
                    seg_mask = 16'hffff;
                end else begin
                    seg_mask = 16'($urandom);
                end
                write_mask(seg_mask);
                post_pct = (seg % 2 == 0) ? 70 : 45;
                for (i = 0; i < SEG_ITEMS; i++) begin
                    // Long receiver hold-off while posts keep coming; later a full drain.
                    if (phase == 2 && seg == 1 && i == 10) begin
                        hold_requests++;
                    end
                    if (phase == 2 && seg == 2 && i == 40) begin
                        wait_drained();
                    end
                    send_op(random_op(post_pct, 90 - post_pct), 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Run covered %0d operations under several terminal masks and idle patterns.",
                 ops_sent);
        $display("Replies seen: %0d evictions, %0d dropped posts, %0d records taken.",
                 n_evicted, n_dropped, n_popped);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
